// ===== design/odfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odfd_pkg
// Shared types and constants of the odometry frame deframer: frame marker
// bytes, frame layout positions, result status codes and the result record.
// ----------------------------------------------------------------------------
package odfd_pkg;

    // Frame markers and command code
    localparam logic [7:0] HDR0     = 8'hAE;
    localparam logic [7:0] HDR1     = 8'hEA;
    localparam logic [7:0] TRL0     = 8'hEF;
    localparam logic [7:0] TRL1     = 8'hFE;
    localparam logic [7:0] CMD_ODOM = 8'hA7;

    // Frame layout: byte positions counted from the first header byte
    localparam int POS_START      = 2;
    localparam int POS_LENGTH     = 2;
    localparam int POS_COMMAND    = 3;
    localparam int POS_PAYLOAD    = 4;
    localparam int PAYLOAD_BYTES  = 6;
    localparam int ODOM_MIN_BYTES = POS_PAYLOAD + PAYLOAD_BYTES;
    localparam int LEN_EXTRA      = 4;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_ODOM    = 2'd0,
        STATUS_UNKNOWN = 2'd1,
        STATUS_ERROR   = 2'd2
    } status_t;

    // One result record
    typedef struct packed {
        status_t            status;
        logic [7:0]         command;
        logic [8:0]         frame_bytes;
        logic signed [15:0] vel_x_milli;
        logic signed [15:0] vel_y_milli;
        logic signed [15:0] yaw_rate_milli;
    } result_t;

endpackage

// ===== design/odfd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odfd_in_stage
// Input register: holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
module odfd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Take a new byte whenever the held one is consumed or the slot is empty
    assign byte_ready = !valid_reg || advance;
    assign valid_next = byte_ready ? byte_valid : valid_reg;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the byte on a transfer
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// ===== design/odfd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odfd_core
// Frame state and decode: header hunt, byte counting, field capture and
// trailer / overflow detection, producing at most one result per byte.
// ----------------------------------------------------------------------------
module odfd_core #(
    parameter int MAX_FRAME_BYTES = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              held_valid,
    input  logic [7:0]        held_byte,
    input  logic              advance,
    output logic              produced,
    output odfd_pkg::result_t result
);

    localparam logic [9:0] MAX_COUNT = 10'(MAX_FRAME_BYTES);
    localparam logic [9:0] MIN_ODOM  = 10'(odfd_pkg::ODOM_MIN_BYTES);
    localparam logic [9:0] LEN_ADD   = 10'(odfd_pkg::LEN_EXTRA);
    localparam logic [8:0] P_START   = 9'(odfd_pkg::POS_START);
    localparam logic [8:0] P_LENGTH  = 9'(odfd_pkg::POS_LENGTH);
    localparam logic [8:0] P_COMMAND = 9'(odfd_pkg::POS_COMMAND);
    localparam logic [8:0] P_LAST    = 9'(odfd_pkg::ODOM_MIN_BYTES - 1);

    logic       receiving_reg;
    logic       receiving_next;
    logic [7:0] prev_byte_reg;
    logic [8:0] byte_count_reg;
    logic [8:0] byte_count_next;
    logic [7:0] length_reg;
    logic [7:0] command_reg;
    logic [7:0] payload_reg [odfd_pkg::PAYLOAD_BYTES];

    logic       fire;
    logic [9:0] count;
    logic       trailer_seen;
    logic       header_seen;
    logic       frame_end;
    logic       length_ok;
    logic [7:0] cmd_now;
    logic [7:0] last_payload;

    assign fire         = held_valid && advance;
    assign count        = {1'b0, byte_count_reg} + 10'd1;
    assign header_seen  = (prev_byte_reg == odfd_pkg::HDR0) && (held_byte == odfd_pkg::HDR1);
    assign trailer_seen = (prev_byte_reg == odfd_pkg::TRL0) && (held_byte == odfd_pkg::TRL1);
    assign length_ok    = (count == ({2'b00, length_reg} + LEN_ADD));

    // Bypass fields that are captured by the same byte that ends the frame
    assign cmd_now      = (byte_count_reg == P_COMMAND) ? held_byte : command_reg;
    assign last_payload = (byte_count_reg == P_LAST) ? held_byte
                                                     : payload_reg[odfd_pkg::PAYLOAD_BYTES-1];

    // Next state and result for the held byte
    always_comb
    begin
        receiving_next     = receiving_reg;
        byte_count_next    = byte_count_reg;
        frame_end          = 1'b0;
        result.status      = odfd_pkg::STATUS_ERROR;
        result.command     = cmd_now;
        result.frame_bytes = count[9] ? 9'h1FF : count[8:0];
        result.vel_x_milli    = '0;
        result.vel_y_milli    = '0;
        result.yaw_rate_milli = '0;

        if (!receiving_reg)
        begin
            if (header_seen)
            begin
                receiving_next  = 1'b1;
                byte_count_next = P_START;
            end
        end
        else if (trailer_seen)
        begin
            receiving_next  = 1'b0;
            byte_count_next = '0;
            frame_end       = 1'b1;
            if (!length_ok)
            begin
                result.status = odfd_pkg::STATUS_ERROR;
            end
            else if (cmd_now == odfd_pkg::CMD_ODOM)
            begin
                if (count < MIN_ODOM)
                begin
                    result.status = odfd_pkg::STATUS_ERROR;
                end
                else
                begin
                    result.status         = odfd_pkg::STATUS_ODOM;
                    result.vel_x_milli    = {payload_reg[0], payload_reg[1]};
                    result.vel_y_milli    = {payload_reg[2], payload_reg[3]};
                    result.yaw_rate_milli = {payload_reg[4], last_payload};
                end
            end
            else
            begin
                result.status = odfd_pkg::STATUS_UNKNOWN;
            end
        end
        else if (count >= MAX_COUNT)
        begin
            // End an oversize frame with an error result and go back to hunting
            receiving_next  = 1'b0;
            byte_count_next = '0;
            frame_end       = 1'b1;
        end
        else
        begin
            byte_count_next = count[8:0];
        end
    end

    assign produced = held_valid && frame_end;

    // Advance control state on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg  <= 1'b0;
            prev_byte_reg  <= '0;
            byte_count_reg <= '0;
        end
        else if (fire)
        begin
            receiving_reg  <= receiving_next;
            prev_byte_reg  <= held_byte;
            byte_count_reg <= byte_count_next;
        end
    end

    // Capture length, command and payload bytes at their frame positions
    always_ff @(posedge clk)
    begin
        if (fire && receiving_reg)
        begin
            if (byte_count_reg == P_LENGTH)
            begin
                length_reg <= held_byte;
            end
            if (byte_count_reg == P_COMMAND)
            begin
                command_reg <= held_byte;
            end
            for (int i = 0; i < odfd_pkg::PAYLOAD_BYTES; i++)
            begin
                if (byte_count_reg == 9'(odfd_pkg::POS_PAYLOAD + i))
                begin
                    payload_reg[i] <= held_byte;
                end
            end
        end
    end

    // Idle implies a cleared count
    assert property (@(posedge clk) disable iff (!rst_n)
        !receiving_reg |-> (byte_count_reg == '0))
        else $error("byte count not cleared while hunting");

    // The count never reaches the frame size limit while receiving
    assert property (@(posedge clk) disable iff (!rst_n)
        receiving_reg |-> ({1'b0, byte_count_reg} < MAX_COUNT))
        else $error("byte count beyond frame limit");

    // A result only comes out of a frame in progress, and ends it
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && produced) |=> !receiving_reg)
        else $error("frame still open after its result");

    // Odometry results always carry a complete payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (produced && result.status == odfd_pkg::STATUS_ODOM)
            |-> (result.frame_bytes >= 9'(odfd_pkg::ODOM_MIN_BYTES)))
        else $error("odometry result from a short frame");

    // Velocities are zero unless the frame decoded as odometry
    assert property (@(posedge clk) disable iff (!rst_n)
        (produced && result.status != odfd_pkg::STATUS_ODOM)
            |-> (result.vel_x_milli == '0 && result.vel_y_milli == '0
                 && result.yaw_rate_milli == '0))
        else $error("velocity set on a non-odometry result");

endmodule

// ===== design/odfd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odfd_out_stage
// Result register: holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module odfd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              produced,
    input  odfd_pkg::result_t result,
    output logic              advance,
    output logic              result_valid,
    input  logic              result_ready,
    output odfd_pkg::result_t result_out
);

    logic              valid_reg;
    odfd_pkg::result_t result_reg;

    // The slot frees up when empty or when its result is transferred
    assign advance = !valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= produced;
        end
    end

    // Load a new result record
    always_ff @(posedge clk)
    begin
        if (advance && produced)
        begin
            result_reg <= result;
        end
    end

    assign result_valid = valid_reg;
    assign result_out   = result_reg;

endmodule

// ===== design/odometry_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_frame_deframer
// Serial byte deframer for odometry frames with a registered result output.
// ----------------------------------------------------------------------------
// Accepts one byte per clock cycle on the byte channel with no bubbles while
// the result channel keeps up. Each byte passes through an input register and
// the frame decode. The result register loads from the decode of the byte that
// ends the frame (the trailer pair or an overflow) once that byte is held in
// the input register and the result slot is free; result_valid is registered.
// Backpressure on the result channel holds the byte in the input register
// whenever a result is waiting and the consumer does not take it in that
// cycle, whether or not the held byte ends a frame, and stalls byte intake
// once the input register is full. Status 0 carries three big-endian
// velocities, status 1 marks an unknown command, status 2 a length,
// short-payload or oversize frame error.
// ----------------------------------------------------------------------------
module odometry_frame_deframer #(
    parameter int MAX_FRAME_BYTES = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  logic [7:0]         rx_byte,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [1:0]         status,
    output logic [7:0]         command,
    output logic [8:0]         frame_bytes,
    output logic signed [15:0] vel_x_milli,
    output logic signed [15:0] vel_y_milli,
    output logic signed [15:0] yaw_rate_milli
);

    logic              advance;
    logic              held_valid;
    logic [7:0]        held_byte;
    logic              produced;
    odfd_pkg::result_t result;
    odfd_pkg::result_t result_out;

    odfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    odfd_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .advance    (advance),
        .produced   (produced),
        .result     (result)
    );

    odfd_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .produced     (produced),
        .result       (result),
        .advance      (advance),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_out   (result_out)
    );

    // Break the result record out onto the ports
    assign status         = result_out.status;
    assign command        = result_out.command;
    assign frame_bytes    = result_out.frame_bytes;
    assign vel_x_milli    = result_out.vel_x_milli;
    assign vel_y_milli    = result_out.vel_y_milli;
    assign yaw_rate_milli = result_out.yaw_rate_milli;

endmodule

// ===== tb/odometry_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_frame_deframer_tb
// Self-checking bench for the odometry frame deframer.
// ----------------------------------------------------------------------------
// A short table of hand-written frames checks error codes, extreme velocity
// words, trailer bytes while hunting and a header pair inside a frame. After
// it comes a random stream of well-formed frames with random content, frames
// with a wrong length byte, short frames, line noise and up to two oversize frames.
// A behavioral decoder inside the bench predicts the result of every byte
// transfer, and each result transfer is compared field by field with the
// oldest prediction. Both channels idle at random; the result side holds off
// once long enough to stall byte intake, and the byte side drains once.
// ----------------------------------------------------------------------------
module odometry_frame_deframer_tb;

    localparam int FRAME_LIMIT   = 512;
    localparam int ITEM_TARGET   = 1500;
    localparam int MAX_GAP       = 14;
    localparam int HOLD_AFTER    = 40;
    localparam int HOLD_CYCLES   = 800;
    localparam int DRAIN_CYCLES  = 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int OVERSIZE_BODY = 520;

    // One row of the directed table: a byte and, where given, its result
    typedef struct packed {
        logic [7:0]        data;
        logic              typed;
        odfd_pkg::result_t want;
    } table_row_t;

    localparam odfd_pkg::result_t NO_RESULT = '0;

    localparam table_row_t DIRECTED_ROWS [32] = '{
        // trailer pair while hunting: nothing comes out
        '{8'hEF, 1'b0, NO_RESULT},
        '{8'hFE, 1'b0, NO_RESULT},
        // shortest frame, length byte does not match
        '{8'hAE, 1'b0, NO_RESULT},
        '{8'hEA, 1'b0, NO_RESULT},
        '{8'hEF, 1'b0, NO_RESULT},
        '{8'hFE, 1'b1,
          '{odfd_pkg::STATUS_ERROR, 8'hFE, 9'd4, 16'h0000, 16'h0000, 16'h0000}},
        // odometry command without a full payload
        '{8'hAE, 1'b0, NO_RESULT},
        '{8'hEA, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, NO_RESULT},
        '{8'hA7, 1'b0, NO_RESULT},
        '{8'hEF, 1'b0, NO_RESULT},
        '{8'hFE, 1'b1,
          '{odfd_pkg::STATUS_ERROR, 8'hA7, 9'd6, 16'h0000, 16'h0000, 16'h0000}},
        // header pair inside a frame is data, unknown command
        '{8'hAE, 1'b0, NO_RESULT},
        '{8'hEA, 1'b0, NO_RESULT},
        '{8'h04, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hAE, 1'b0, NO_RESULT},
        '{8'hEA, 1'b0, NO_RESULT},
        '{8'hEF, 1'b0, NO_RESULT},
        '{8'hFE, 1'b1,
          '{odfd_pkg::STATUS_UNKNOWN, 8'h00, 9'd8, 16'h0000, 16'h0000, 16'h0000}},
        // odometry frame with extreme velocity words
        '{8'hAE, 1'b0, NO_RESULT},
        '{8'hEA, 1'b0, NO_RESULT},
        '{8'h08, 1'b0, NO_RESULT},
        '{8'hA7, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hEF, 1'b0, NO_RESULT},
        '{8'hFE, 1'b1,
          '{odfd_pkg::STATUS_ODOM, 8'hA7, 9'd12, 16'h7FFF, 16'h8000, 16'hFFFF}}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_ready;
    logic [7:0]         rx_byte = 8'h00;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [1:0]         status;
    logic [7:0]         command;
    logic [8:0]         frame_bytes;
    logic signed [15:0] vel_x_milli;
    logic signed [15:0] vel_y_milli;
    logic signed [15:0] yaw_rate_milli;

    // Decoder state kept by the bench
    logic               dec_receiving = 1'b0;
    logic [7:0]         dec_prev = 8'h00;
    int unsigned        dec_count = 0;
    logic [7:0]         dec_length = 8'h00;
    logic [7:0]         dec_command = 8'h00;
    logic [7:0]         dec_payload [odfd_pkg::PAYLOAD_BYTES];

    odfd_pkg::result_t  pending_results [$];
    odfd_pkg::result_t  oldest;
    int unsigned        mismatch_count = 0;
    int unsigned        bytes_sent = 0;
    int unsigned        results_taken = 0;
    int unsigned        quiet_cycles = 0;
    logic               sender_burst = 1'b0;

    odometry_frame_deframer #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .rx_byte        (rx_byte),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .status         (status),
        .command        (command),
        .frame_bytes    (frame_bytes),
        .vel_x_milli    (vel_x_milli),
        .vel_y_milli    (vel_y_milli),
        .yaw_rate_milli (yaw_rate_milli)
    );

    // Clock and reset
    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
    end

    // Advance the decoder by one byte; return 1 when a frame ends or aborts
    function automatic bit deframe_byte(input logic [7:0] b,
                                        output odfd_pkg::result_t res);
        logic [7:0]  last;
        int unsigned pos;
        int unsigned cnt;
        bit          done;
        last = dec_prev;
        dec_prev = b;
        done = 1'b0;
        res = '0;
        if (!dec_receiving)
        begin
            if (last == odfd_pkg::HDR0 && b == odfd_pkg::HDR1)
            begin
                dec_receiving = 1'b1;
                dec_count = odfd_pkg::POS_START;
            end
        end
        else
        begin
            pos = dec_count;
            cnt = pos + 1;
            // capture the leading fields as they pass
            if (pos == odfd_pkg::POS_LENGTH)
                dec_length = b;
            else if (pos == odfd_pkg::POS_COMMAND)
                dec_command = b;
            else if (pos >= odfd_pkg::POS_PAYLOAD && pos < odfd_pkg::ODOM_MIN_BYTES)
                dec_payload[pos - odfd_pkg::POS_PAYLOAD] = b;

            if ((last == odfd_pkg::TRL0 && b == odfd_pkg::TRL1) || cnt >= FRAME_LIMIT)
            begin
                dec_receiving = 1'b0;
                dec_count = 0;
                done = 1'b1;
                res.command = dec_command;
                res.frame_bytes = (cnt > 511) ? 9'd511 : cnt[8:0];
                if (!(last == odfd_pkg::TRL0 && b == odfd_pkg::TRL1))
                    res.status = odfd_pkg::STATUS_ERROR;
                else if (cnt != dec_length + odfd_pkg::LEN_EXTRA)
                    res.status = odfd_pkg::STATUS_ERROR;
                else if (dec_command != odfd_pkg::CMD_ODOM)
                    res.status = odfd_pkg::STATUS_UNKNOWN;
                else if (cnt < odfd_pkg::ODOM_MIN_BYTES)
                    res.status = odfd_pkg::STATUS_ERROR;
                else
                begin
                    res.status = odfd_pkg::STATUS_ODOM;
                    res.vel_x_milli = {dec_payload[0], dec_payload[1]};
                    res.vel_y_milli = {dec_payload[2], dec_payload[3]};
                    res.yaw_rate_milli = {dec_payload[4], dec_payload[5]};
                end
            end
            else
                dec_count = cnt;
        end
        return done;
    endfunction

    // Offer one byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input odfd_pkg::result_t want);
        int unsigned       gap;
        odfd_pkg::result_t predicted;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!byte_ready);
        bytes_sent++;
        if (deframe_byte(b, predicted) && !typed)
            pending_results.push_back(predicted);
        if (typed)
            pending_results.push_back(want);
    endtask

    // Build one random frame, broken frame or burst of noise and send it
    task automatic send_random_frame();
        logic [7:0]  frame_q [$];
        int unsigned kind;
        int unsigned n;
        logic [7:0]  cmd_byte;
        logic [7:0]  len_byte;
        kind = $urandom_range(0, 99);
        sender_burst = ($urandom_range(0, 3) == 0);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
        if (kind < 90)
        begin
            if (kind < 45 || (kind >= 70 && kind < 80))
            begin
                // odometry frame, now and then a long tail before the trailer
                cmd_byte = odfd_pkg::CMD_ODOM;
                n = odfd_pkg::PAYLOAD_BYTES;
                n += ($urandom_range(0, 49) == 0) ? $urandom_range(4, 247)
                                                  : $urandom_range(0, 3);
            end
            else if (kind < 70)
            begin
                cmd_byte = 8'($urandom_range(0, 255));
                n = $urandom_range(0, 8);
            end
            else
            begin
                // short frame
                cmd_byte = $urandom_range(0, 1) ? odfd_pkg::CMD_ODOM
                                                : 8'($urandom_range(0, 255));
                n = $urandom_range(0, odfd_pkg::PAYLOAD_BYTES - 1);
            end
            len_byte = 8'(n + 2);
            if (kind >= 70 && kind < 80)
                len_byte ^= 8'($urandom_range(1, 255));
            frame_q.push_back(odfd_pkg::HDR0);
            frame_q.push_back(odfd_pkg::HDR1);
            frame_q.push_back(len_byte);
            frame_q.push_back(cmd_byte);
            repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
            frame_q.push_back(odfd_pkg::TRL0);
            frame_q.push_back(odfd_pkg::TRL1);
        end
        else
        begin
            // line noise, ending in a stray trailer pair or header byte
            repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
            begin
                frame_q.push_back(odfd_pkg::TRL0);
                frame_q.push_back(odfd_pkg::TRL1);
            end
            else
                frame_q.push_back(odfd_pkg::HDR0);
        end
        foreach (frame_q[i])
            send_byte(frame_q[i], 1'b0, NO_RESULT);
    endtask

    // Send a header and more bytes than a frame may hold, never a trailer pair
    task automatic send_oversize_frame();
        logic [7:0] last;
        logic [7:0] b;
        sender_burst = 1'b1;
        send_byte(odfd_pkg::HDR0, 1'b0, NO_RESULT);
        send_byte(odfd_pkg::HDR1, 1'b0, NO_RESULT);
        last = odfd_pkg::HDR1;
        repeat (OVERSIZE_BODY)
        begin
            b = 8'($urandom_range(0, 255));
            if (last == odfd_pkg::TRL0 && b == odfd_pkg::TRL1)
                b = 8'hFD;
            send_byte(b, 1'b0, NO_RESULT);
            last = b;
        end
    endtask

    // Byte side: directed table, then random frames
    initial
    begin : byte_source
        int unsigned frame_idx;
        for (int i = 0; i < 32; i++)
            dec_payload[i % odfd_pkg::PAYLOAD_BYTES] = 8'h00;
        @(posedge rst_n);
        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        frame_idx = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            if (frame_idx == 30 || frame_idx == 110)
                send_oversize_frame();
            else
                send_random_frame();
            // pause once until every result is back
            if (frame_idx == 70)
            begin
                @(negedge clk);
                byte_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge clk);
            end
            frame_idx++;
        end
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side: random ready gaps, bursts, one long hold-off
    initial
    begin : result_sink
        int unsigned gap;
        int unsigned burst_left;
        burst_left = 0;
        @(posedge rst_n);
        forever
        begin
            if (burst_left > 0)
            begin
                gap = 0;
                burst_left--;
            end
            else
            begin
                gap = $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 5) == 0)
                    burst_left = $urandom_range(4, 20);
            end
            if (results_taken == HOLD_AFTER)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            results_taken++;
        end
    end

    task automatic check_field(input string fname, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result transfer and watch for a hung channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no result pending (status %0d)", status);
                    mismatch_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    check_field("status", oldest.status, status);
                    check_field("command", oldest.command, command);
                    check_field("frame_bytes", oldest.frame_bytes, frame_bytes);
                    check_field("vel_x_milli", oldest.vel_x_milli, vel_x_milli);
                    check_field("vel_y_milli", oldest.vel_y_milli, vel_y_milli);
                    check_field("yaw_rate_milli", oldest.yaw_rate_milli, yaw_rate_milli);
                end
            end
            if ((byte_valid && byte_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $error("no transfer for %0d cycles", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

// ===== odometry_frame_deframer.f =====
design/odfd_pkg.sv
design/odfd_in_stage.sv
design/odfd_core.sv
design/odfd_out_stage.sv
design/odometry_frame_deframer.sv
tb/odometry_frame_deframer_tb.sv
